### rtl/pdwt_pkg.sv
// Shared constants and types for the percentile difference weighted tally unit.
`default_nettype none

package pdwt_pkg;

	localparam int GENE_W = 10;
	localparam int VAL_W = 32;
	localparam int FRAC_W = 16;
	localparam int MODE_W = 2;
	localparam int TALLY_W = 40;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int PROD_W = FRAC_W + 1 + VAL_W + 1;

	localparam int GENES_DEFAULT = 1024;
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;
	localparam int INFLIGHT_MAX = 3 + MID_DEPTH + OUT_DEPTH;

	localparam logic [CFG_IDX_W-1:0] REG_RANK_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_FRACTION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_FRACTION = 2'd2;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_ACCUM = 1'b1;

	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

	typedef struct packed {
		logic [MODE_W-1:0] rank_mode;
		logic [FRAC_W-1:0] x_fraction;
		logic [FRAC_W-1:0] y_fraction;
	} pdwt_cfg_t;

	typedef struct packed {
		logic              op;
		logic [GENE_W-1:0] gene;
		logic [VAL_W-1:0]  abs_diff;
		logic [VAL_W-1:0]  weight;
		logic [VAL_W-1:0]  threshold;
	} pdwt_work_t;

	typedef struct packed {
		logic [GENE_W-1:0]  gene;
		logic               exceeded;
		logic [TALLY_W-1:0] tally;
	} pdwt_result_t;

endpackage

`default_nettype wire

### rtl/pdwt_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module pdwt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    we,
	input  wire logic [AW-1:0]           waddr,
	input  wire logic [WIDTH-1:0]        wdata,
	input  wire logic                    re,
	input  wire logic [AW-1:0]           raddr,
	output logic      [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/pdwt_fifo.sv
// Small register-based queue with push/full and pop/empty handshakes.
`default_nettype none

module pdwt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/pdwt_front.sv
// Front end: accepts requests and forms the absolute percentile difference.
`default_nettype none

module pdwt_front import pdwt_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pdwt_cfg_t         cfg,
	input  wire logic              push,
	output logic                   full,
	input  wire logic              operation,
	input  wire logic [GENE_W-1:0] gene_index,
	input  wire logic [VAL_W-1:0]  x_value,
	input  wire logic [VAL_W-1:0]  x_next,
	input  wire logic [VAL_W-1:0]  y_value,
	input  wire logic [VAL_W-1:0]  y_next,
	input  wire logic [VAL_W-1:0]  weight,
	input  wire logic [VAL_W-1:0]  threshold,
	output logic                   q_push,
	output pdwt_work_t             q_data,
	input  wire logic              q_full
);

	logic              valid_s1;
	logic              op_s1;
	logic [GENE_W-1:0] gene_s1;
	logic [VAL_W-1:0]  xv_s1;
	logic [VAL_W-1:0]  xn_s1;
	logic [VAL_W-1:0]  yv_s1;
	logic [VAL_W-1:0]  yn_s1;
	logic [VAL_W-1:0]  weight_s1;
	logic [VAL_W-1:0]  thr_s1;

	logic              valid_s2;
	logic              op_s2;
	logic [GENE_W-1:0] gene_s2;
	logic [VAL_W-1:0]  xv_s2;
	logic [VAL_W-1:0]  yv_s2;
	logic [PROD_W-1:0] xprod_s2;
	logic [PROD_W-1:0] yprod_s2;
	logic [VAL_W-1:0]  weight_s2;
	logic [VAL_W-1:0]  thr_s2;

	logic              s1_load;
	logic              s1_go;
	logic              s2_load;
	logic              s2_go;
	logic              interp_x;
	logic              interp_y;
	logic signed [VAL_W:0]    xdiff;
	logic signed [VAL_W:0]    ydiff;
	logic signed [PROD_W-1:0] xprod;
	logic signed [PROD_W-1:0] yprod;
	logic [VAL_W-1:0]  px;
	logic [VAL_W-1:0]  py;
	logic [VAL_W:0]    diff;
	logic [VAL_W:0]    neg_diff;

	assign s2_go = valid_s2 && !q_full;
	assign s2_load = !valid_s2 || s2_go;
	assign s1_go = valid_s1 && s2_load;
	assign s1_load = !valid_s1 || s1_go;
	assign full = !s1_load;

	// Mode three interpolates both groups, like mode two.
	assign interp_x = (cfg.rank_mode != '0);
	assign interp_y = cfg.rank_mode[1];

	assign xdiff = $signed({xn_s1[VAL_W-1], xn_s1}) - $signed({xv_s1[VAL_W-1], xv_s1});
	assign ydiff = $signed({yn_s1[VAL_W-1], yn_s1}) - $signed({yv_s1[VAL_W-1], yv_s1});
	assign xprod = PROD_W'($signed({1'b0, cfg.x_fraction})) * PROD_W'(xdiff);
	assign yprod = PROD_W'($signed({1'b0, cfg.y_fraction})) * PROD_W'(ydiff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_load) begin
				valid_s1 <= push;
			end
			if (s2_load) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && push) begin
			op_s1 <= operation;
			gene_s1 <= gene_index;
			xv_s1 <= x_value;
			xn_s1 <= x_next;
			yv_s1 <= y_value;
			yn_s1 <= y_next;
			weight_s1 <= weight;
			thr_s1 <= threshold;
		end
		if (s1_go) begin
			op_s2 <= op_s1;
			gene_s2 <= gene_s1;
			xv_s2 <= xv_s1;
			yv_s2 <= yv_s1;
			xprod_s2 <= interp_x ? xprod : '0;
			yprod_s2 <= interp_y ? yprod : '0;
			weight_s2 <= weight_s1;
			thr_s2 <= thr_s1;
		end
	end

	// The interpolated value lies between its two ranks, so 32 bits are enough.
	assign px = xv_s2 + xprod_s2[FRAC_W +: VAL_W];
	assign py = yv_s2 + yprod_s2[FRAC_W +: VAL_W];
	assign diff = {px[VAL_W-1], px} - {py[VAL_W-1], py};
	assign neg_diff = '0 - diff;

	always_comb begin
		q_data.op = op_s2;
		q_data.gene = gene_s2;
		q_data.abs_diff = diff[VAL_W] ? neg_diff[VAL_W-1:0] : diff[VAL_W-1:0];
		q_data.weight = weight_s2;
		q_data.threshold = thr_s2;
	end

	assign q_push = s2_go;

endmodule

`default_nettype wire

### rtl/pdwt_back.sv
// Back end: per-gene threshold and tally stores with read-modify-write update.
`default_nettype none

module pdwt_back import pdwt_pkg::*; #(
	parameter int MAX_GENES = GENES_DEFAULT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_empty,
	input  wire pdwt_work_t q_data,
	output logic            q_pop,
	input  wire logic       r_full,
	output logic            r_push,
	output pdwt_result_t    r_data
);

	localparam int AW = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;
	localparam int EW = AW + GENE_W;

	logic               valid_s1;
	logic               op_s1;
	logic [GENE_W-1:0]  gene_s1;
	logic               inrange_s1;
	logic [VAL_W-1:0]   ad_s1;
	logic [VAL_W-1:0]   weight_s1;
	logic [VAL_W-1:0]   thr_s1;
	logic               fwd_thr_hit_s1;
	logic               fwd_tally_hit_s1;
	logic [VAL_W-1:0]   fwd_thr_s1;
	logic [TALLY_W-1:0] fwd_tally_s1;

	logic               fire;
	logic               load;
	logic               take;
	logic [EW-1:0]      q_gene_ext;
	logic [EW-1:0]      gene_ext_s1;
	logic               q_inrange;
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      waddr;
	logic               thr_we;
	logic               tally_we;
	logic [VAL_W-1:0]   thr_rd;
	logic [TALLY_W-1:0] tally_rd;
	logic [VAL_W-1:0]   thr_cur;
	logic [TALLY_W-1:0] tally_cur;
	logic [TALLY_W:0]   sum;
	logic [TALLY_W-1:0] sat;
	logic               reached;
	logic               exceeded;
	logic [TALLY_W-1:0] tally_new;

	assign fire = valid_s1 && !r_full;
	assign load = !valid_s1 || fire;
	assign take = load && !q_empty;
	assign q_pop = take;

	assign q_gene_ext = EW'(q_data.gene);
	assign q_inrange = (q_gene_ext < EW'(MAX_GENES));
	assign raddr = q_gene_ext[AW-1:0];
	assign gene_ext_s1 = EW'(gene_s1);
	assign waddr = gene_ext_s1[AW-1:0];

	assign thr_we = fire && inrange_s1 && (op_s1 == OP_LOAD);
	assign tally_we = fire && inrange_s1;

	pdwt_ram #(
		.WIDTH(VAL_W),
		.DEPTH(MAX_GENES)
	) u_thr_ram (
		.clk(clk),
		.we(thr_we),
		.waddr(waddr),
		.wdata(thr_s1),
		.re(take),
		.raddr(raddr),
		.rdata(thr_rd)
	);

	pdwt_ram #(
		.WIDTH(TALLY_W),
		.DEPTH(MAX_GENES)
	) u_tally_ram (
		.clk(clk),
		.we(tally_we),
		.waddr(waddr),
		.wdata(tally_new),
		.re(take),
		.raddr(raddr),
		.rdata(tally_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= !q_empty;
		end
	end

	// A write in the same cycle as the read is not seen by the RAM, so it is forwarded.
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= q_data.op;
			gene_s1 <= q_data.gene;
			inrange_s1 <= q_inrange;
			ad_s1 <= q_data.abs_diff;
			weight_s1 <= q_data.weight;
			thr_s1 <= q_data.threshold;
			fwd_thr_hit_s1 <= thr_we && (waddr == raddr);
			fwd_tally_hit_s1 <= tally_we && (waddr == raddr);
			fwd_thr_s1 <= thr_s1;
			fwd_tally_s1 <= tally_new;
		end
	end

	assign thr_cur = fwd_thr_hit_s1 ? fwd_thr_s1 : thr_rd;
	assign tally_cur = fwd_tally_hit_s1 ? fwd_tally_s1 : tally_rd;
	assign sum = {1'b0, tally_cur} + (TALLY_W + 1)'(weight_s1);
	assign sat = sum[TALLY_W] ? TALLY_MAX : sum[TALLY_W-1:0];
	assign reached = (ad_s1 >= thr_cur);

	always_comb begin
		exceeded = 1'b0;
		tally_new = '0;
		if (inrange_s1 && (op_s1 == OP_ACCUM)) begin
			exceeded = reached;
			tally_new = reached ? sat : tally_cur;
		end
	end

	assign r_push = fire;

	always_comb begin
		r_data.gene = gene_s1;
		r_data.exceeded = exceeded;
		r_data.tally = tally_new;
	end

endmodule

`default_nettype wire

### rtl/percentile_diff_weighted_tally_unit.sv
// Path: front stages s1 and s2, the middle queue, back stage s1, then the output queue to pop.
// Throughput: one request per cycle when not stalled, set by the tally RAM read-modify-write.
// Reset: arst_n clears the queues, pipeline valids and configuration registers (all zero).
// The threshold and tally stores are not cleared; a gene must be loaded before it is accumulated.
// Configuration writes take effect at the next clock edge.
`default_nettype none

module percentile_diff_weighted_tally_unit import pdwt_pkg::*; #(
	parameter int MAX_GENES = GENES_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic                  operation,
	input  wire logic [GENE_W-1:0]     gene_index,
	input  wire logic [VAL_W-1:0]      x_value,
	input  wire logic [VAL_W-1:0]      x_next,
	input  wire logic [VAL_W-1:0]      y_value,
	input  wire logic [VAL_W-1:0]      y_next,
	input  wire logic [VAL_W-1:0]      weight,
	input  wire logic [VAL_W-1:0]      threshold,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [GENE_W-1:0]          gene_out,
	output logic                       exceeded,
	output logic [TALLY_W-1:0]         tally
);

	pdwt_cfg_t    cfg_q;
	logic         mid_push;
	pdwt_work_t   mid_wdata;
	logic         mid_full;
	logic         mid_pop;
	pdwt_work_t   mid_rdata;
	logic         mid_empty;
	logic         res_push;
	pdwt_result_t res_wdata;
	logic         res_full;
	pdwt_result_t res_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_RANK_MODE: cfg_q.rank_mode <= cfg_data[MODE_W-1:0];
				REG_X_FRACTION: cfg_q.x_fraction <= cfg_data[FRAC_W-1:0];
				REG_Y_FRACTION: cfg_q.y_fraction <= cfg_data[FRAC_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	pdwt_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.push(push),
		.full(full),
		.operation(operation),
		.gene_index(gene_index),
		.x_value(x_value),
		.x_next(x_next),
		.y_value(y_value),
		.y_next(y_next),
		.weight(weight),
		.threshold(threshold),
		.q_push(mid_push),
		.q_data(mid_wdata),
		.q_full(mid_full)
	);

	pdwt_fifo #(
		.WIDTH($bits(pdwt_work_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(mid_push),
		.wdata(mid_wdata),
		.full(mid_full),
		.pop(mid_pop),
		.rdata(mid_rdata),
		.empty(mid_empty)
	);

	pdwt_back #(
		.MAX_GENES(MAX_GENES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(mid_empty),
		.q_data(mid_rdata),
		.q_pop(mid_pop),
		.r_full(res_full),
		.r_push(res_push),
		.r_data(res_wdata)
	);

	pdwt_fifo #(
		.WIDTH($bits(pdwt_result_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(res_wdata),
		.full(res_full),
		.pop(pop),
		.rdata(res_rdata),
		.empty(empty)
	);

	assign gene_out = res_rdata.gene;
	assign exceeded = res_rdata.exceeded;
	assign tally = res_rdata.tally;

endmodule

`default_nettype wire

### rtl/pdwt_checker.sv
// Port-level checker for the tally unit, bound to the top level.
`default_nettype none

module pdwt_checker import pdwt_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               push,
	input wire logic               full,
	input wire logic               pop,
	input wire logic               empty,
	input wire logic [GENE_W-1:0]  gene_out,
	input wire logic               exceeded,
	input wire logic [TALLY_W-1:0] tally
);

	localparam int OW = $clog2(INFLIGHT_MAX + 2);

	logic [OW-1:0] outstanding_q;
	logic          req_in;
	logic          req_out;

	assign req_in = push && !full;
	assign req_out = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			case ({req_in, req_out})
				2'b10: outstanding_q <= outstanding_q + 1'b1;
				2'b01: outstanding_q <= outstanding_q - 1'b1;
				default: outstanding_q <= outstanding_q;
			endcase
		end
	end

	// A waiting result holds its place and value until it is popped.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(gene_out) && $stable(exceeded) && $stable(tally))
		else $error("waiting result changed before it was popped");

	// No result appears without an accepted request behind it.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q == '0 |-> empty)
		else $error("result shown with no request outstanding");

	// An idle unit always takes a request.
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q == '0 |-> !full)
		else $error("unit refuses requests while idle");

	// The number of requests in flight never exceeds the storage of the pipeline.
	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= OW'(INFLIGHT_MAX))
		else $error("more requests in flight than the unit can hold");

endmodule

bind percentile_diff_weighted_tally_unit pdwt_checker u_checker (.*);

`default_nettype wire
